/* design/slab_free_list_allocator_assert.svh */
// assertion macros for the slab free-list allocator
// used by the top level only, depends on nothing
`ifndef SLAB_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SLAB_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define SFLA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sfla same-cycle check failed");

// next-cycle implication
`define SFLA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sfla next-cycle check failed");

`endif

/* design/sfla_pkg.sv */
// shared constants and types of the slab free-list allocator
// no dependencies
package sfla_pkg;

    localparam int MAX_BLOCKS = 8;
    localparam int MAX_SLOTS  = 64;
    localparam int BLK_W      = 3;
    localparam int SLOT_W     = 6;
    localparam int ADDR_W     = BLK_W + SLOT_W;
    localparam int NSLOTS     = MAX_BLOCKS * MAX_SLOTS;
    localparam int CAP_W      = 7;
    localparam int LIM_W      = 4;
    localparam int CNT_W      = 32;
    localparam int FS_W       = 10;
    localparam int WORD_W     = SLOT_W + 1;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_TRIM  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOBLK   = 2'd1;
    localparam logic [1:0] ST_BADHDL  = 2'd2;
    localparam logic [1:0] ST_DBLFREE = 2'd3;

    localparam logic [1:0] LST_PARTIAL = 2'd0;
    localparam logic [1:0] LST_FULL    = 2'd1;
    localparam logic [1:0] LST_EMPTY   = 2'd2;
    localparam logic [1:0] LST_NONE    = 2'd3;

    localparam logic CFG_SLOTS = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef struct packed {
        logic              is_free;
        logic [SLOT_W-1:0] nxt;
    } slot_word_t;

    typedef logic [MAX_BLOCKS-1:0][MAX_BLOCKS-1:0] order_t;

endpackage

/* design/sfla_ram.sv */
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
module sfla_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 7,
    parameter int AW    = 9
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

/* design/slab_free_list_allocator.sv */
// Slab free-list allocator, top level.
// Input channel s_*: one word per request (allocate, free, trim, clear).
// Result channel m_*: exactly one word per request, carrying status,
// allocated handle, live block count, saturating counters and free slots.
// Config channel cfg_*: index 0 slots per block, index 1 block limit;
// always ready; must be written between requests, the block does not enforce it.
// Slot links and slot free flags live in a 512-entry ram with registered
// read; each allocate or free is a read-modify-write of one entry.
// Per-block heads, counts and list order are kept in a small block table.
// A free checks the handle, then reads its slot and, unless it is already
// free, rewrites it; an allocate picks a block, then reads and rewrites its
// head slot. A bad handle or no available block goes straight to the result.
// When a block is brought in, its free list is first written one slot per
// cycle. Trim visits every block; clear also rewrites each live block's list.
// One request is in work at a time; s_ready is high only between requests.
// A finished word sits in the output register while the next request is
// accepted; if m_ready stays low the block holds its next result until the
// register drains.
// Reset empties the pool, clears the counters and restores the config registers.
`include "slab_free_list_allocator_assert.svh"

module slab_free_list_allocator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_req_type,
    input  logic [sfla_pkg::ADDR_W-1:0]  s_free_handle,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [sfla_pkg::ADDR_W-1:0]  m_alloc_handle,
    output logic [sfla_pkg::LIM_W-1:0]   m_blocks_live,
    output logic [sfla_pkg::CNT_W-1:0]   m_total_allocs,
    output logic [sfla_pkg::CNT_W-1:0]   m_total_frees,
    output logic [sfla_pkg::FS_W-1:0]    m_free_slots,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [sfla_pkg::CAP_W-1:0]   cfg_data
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ALLOC    = 4'd1;
    localparam logic [3:0] S_SWEEP    = 4'd2;
    localparam logic [3:0] S_ALLOC_RD = 4'd3;
    localparam logic [3:0] S_ALLOC_WR = 4'd4;
    localparam logic [3:0] S_FREE     = 4'd5;
    localparam logic [3:0] S_FREE_WR  = 4'd6;
    localparam logic [3:0] S_TRIM     = 4'd7;
    localparam logic [3:0] S_CLEAR    = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    localparam logic [sfla_pkg::BLK_W-1:0] LAST_BLK = sfla_pkg::BLK_W'(sfla_pkg::MAX_BLOCKS - 1);
    localparam logic [sfla_pkg::CNT_W-1:0] CNT_SAT  = '1;

    logic [3:0] state_reg, state_next;
    logic [sfla_pkg::CAP_W-1:0] slots_reg;
    logic [sfla_pkg::LIM_W-1:0] limit_reg;

    logic [1:0]                  req_reg, req_next;
    logic [sfla_pkg::ADDR_W-1:0] hdl_reg, hdl_next;
    logic [1:0]                  status_reg, status_next;
    logic [sfla_pkg::ADDR_W-1:0] ahdl_reg, ahdl_next;
    logic [sfla_pkg::BLK_W-1:0]  blk_reg, blk_next;
    logic [sfla_pkg::CAP_W-1:0]  idx_reg, idx_next;

    logic [sfla_pkg::MAX_BLOCKS-1:0]                      live_reg, live_next;
    logic [sfla_pkg::MAX_BLOCKS-1:0][sfla_pkg::CAP_W-1:0] cnt_reg, cnt_next;
    logic [sfla_pkg::MAX_BLOCKS-1:0][sfla_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [sfla_pkg::MAX_BLOCKS-1:0][sfla_pkg::SLOT_W-1:0] head_reg, head_next;
    logic [sfla_pkg::MAX_BLOCKS-1:0][1:0]                 lst_reg, lst_next;
    sfla_pkg::order_t                                     order_reg, order_next;

    logic [sfla_pkg::CNT_W-1:0] actr_reg, actr_next;
    logic [sfla_pkg::CNT_W-1:0] fctr_reg, fctr_next;
    logic [sfla_pkg::FS_W-1:0]  fs_reg, fs_next;

    logic                        mem_we;
    logic [sfla_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
    sfla_pkg::slot_word_t        mem_wdata, mem_rdata;

    logic                        out_load;
    logic [sfla_pkg::CAP_W-1:0]  eff_cap;
    logic [sfla_pkg::LIM_W-1:0]  eff_lim;
    logic [sfla_pkg::LIM_W-1:0]  live_cnt;
    logic                        free_found;
    logic [sfla_pkg::BLK_W-1:0]  free_blk;
    logic                        part_found, empty_found;
    logic [sfla_pkg::BLK_W-1:0]  part_head, empty_head;
    logic [sfla_pkg::CAP_W-1:0]  idx_plus;
    logic [sfla_pkg::CAP_W-1:0]  cnt_dec, cnt_inc;
    logic [sfla_pkg::BLK_W-1:0]  fblk;
    logic [sfla_pkg::SLOT_W-1:0] fslot;

    function automatic logic [sfla_pkg::BLK_W:0] find_head(
        input logic [sfla_pkg::MAX_BLOCKS-1:0] mbr,
        input sfla_pkg::order_t                ord
    );
        logic [sfla_pkg::BLK_W:0] res;
        logic                     ok;
        res = '0;
        for (int m = sfla_pkg::MAX_BLOCKS - 1; m >= 0; m--) begin
            ok = mbr[m];
            for (int k = 0; k < sfla_pkg::MAX_BLOCKS; k++) begin
                if (k != m && mbr[k] && !ord[m][k]) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                res = {1'b1, sfla_pkg::BLK_W'(m)};
            end
        end
        return res;
    endfunction

    function automatic sfla_pkg::order_t push_order(
        input sfla_pkg::order_t            ord,
        input logic [sfla_pkg::BLK_W-1:0]  b
    );
        sfla_pkg::order_t res;
        res = ord;
        for (int k = 0; k < sfla_pkg::MAX_BLOCKS; k++) begin
            res[b][k] = 1'b1;
            res[k][b] = 1'b0;
        end
        return res;
    endfunction

    sfla_ram #(
        .DEPTH(sfla_pkg::NSLOTS),
        .WIDTH(sfla_pkg::WORD_W),
        .AW   (sfla_pkg::ADDR_W)
    ) u_slot_ram (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // block table lookups
    always_comb begin
        logic [sfla_pkg::MAX_BLOCKS-1:0] mp, me;
        logic [sfla_pkg::BLK_W:0]        hp, he;
        mp = '0;
        me = '0;
        live_cnt = '0;
        free_found = 1'b0;
        free_blk = '0;
        for (int b = sfla_pkg::MAX_BLOCKS - 1; b >= 0; b--) begin
            mp[b] = live_reg[b] && (lst_reg[b] == sfla_pkg::LST_PARTIAL);
            me[b] = live_reg[b] && (lst_reg[b] == sfla_pkg::LST_EMPTY);
            if (!live_reg[b]) begin
                free_found = 1'b1;
                free_blk = sfla_pkg::BLK_W'(b);
            end
        end
        for (int b = 0; b < sfla_pkg::MAX_BLOCKS; b++) begin
            live_cnt = live_cnt + sfla_pkg::LIM_W'(live_reg[b]);
        end
        hp = find_head(mp, order_reg);
        he = find_head(me, order_reg);
        part_found = hp[sfla_pkg::BLK_W];
        part_head = hp[sfla_pkg::BLK_W-1:0];
        empty_found = he[sfla_pkg::BLK_W];
        empty_head = he[sfla_pkg::BLK_W-1:0];
    end

    assign eff_cap = (slots_reg == '0) ? sfla_pkg::CAP_W'(1) :
                     (slots_reg > sfla_pkg::CAP_W'(sfla_pkg::MAX_SLOTS)) ?
                     sfla_pkg::CAP_W'(sfla_pkg::MAX_SLOTS) : slots_reg;
    assign eff_lim = (limit_reg > sfla_pkg::LIM_W'(sfla_pkg::MAX_BLOCKS)) ?
                     sfla_pkg::LIM_W'(sfla_pkg::MAX_BLOCKS) : limit_reg;

    assign idx_plus = idx_reg + sfla_pkg::CAP_W'(1);
    assign cnt_dec  = (cnt_reg[blk_reg] != '0) ? cnt_reg[blk_reg] - sfla_pkg::CAP_W'(1) : '0;
    assign cnt_inc  = cnt_reg[blk_reg] + sfla_pkg::CAP_W'(1);
    assign fblk     = hdl_reg[sfla_pkg::ADDR_W-1:sfla_pkg::SLOT_W];
    assign fslot    = hdl_reg[sfla_pkg::SLOT_W-1:0];

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_DONE) && (!m_valid || m_ready);

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        hdl_next    = hdl_reg;
        status_next = status_reg;
        ahdl_next   = ahdl_reg;
        blk_next    = blk_reg;
        idx_next    = idx_reg;
        live_next   = live_reg;
        cnt_next    = cnt_reg;
        cap_next    = cap_reg;
        head_next   = head_reg;
        lst_next    = lst_reg;
        order_next  = order_reg;
        actr_next   = actr_reg;
        fctr_next   = fctr_reg;
        fs_next     = fs_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = {blk_reg, head_reg[blk_reg]};

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next    = s_req_type;
                    hdl_next    = s_free_handle;
                    status_next = sfla_pkg::ST_OK;
                    ahdl_next   = '0;
                    blk_next    = '0;
                    case (s_req_type)
                        sfla_pkg::REQ_ALLOC: state_next = S_ALLOC;
                        sfla_pkg::REQ_FREE:  state_next = S_FREE;
                        sfla_pkg::REQ_TRIM:  state_next = S_TRIM;
                        default: begin
                            // reorder: partial, then full, then empty; later visit is newer
                            for (int i = 0; i < sfla_pkg::MAX_BLOCKS; i++) begin
                                for (int j = 0; j < sfla_pkg::MAX_BLOCKS; j++) begin
                                    order_next[i][j] = (i != j) &&
                                        ((lst_reg[i] > lst_reg[j]) ||
                                         ((lst_reg[i] == lst_reg[j]) && !order_reg[i][j]));
                                end
                                if (live_reg[i]) begin
                                    lst_next[i] = sfla_pkg::LST_EMPTY;
                                end
                            end
                            fs_next    = '0;
                            actr_next  = '0;
                            fctr_next  = '0;
                            state_next = S_CLEAR;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                if (part_found) begin
                    blk_next   = part_head;
                    state_next = S_ALLOC_RD;
                end else if (empty_found) begin
                    blk_next             = empty_head;
                    lst_next[empty_head] = sfla_pkg::LST_PARTIAL;
                    order_next           = push_order(order_reg, empty_head);
                    state_next           = S_ALLOC_RD;
                end else if ((live_cnt < eff_lim) && free_found) begin
                    blk_next           = free_blk;
                    live_next[free_blk] = 1'b1;
                    cap_next[free_blk] = eff_cap;
                    cnt_next[free_blk] = eff_cap;
                    head_next[free_blk] = '0;
                    lst_next[free_blk] = sfla_pkg::LST_PARTIAL;
                    order_next         = push_order(order_reg, free_blk);
                    fs_next            = fs_reg + sfla_pkg::FS_W'(eff_cap);
                    idx_next           = '0;
                    state_next         = S_SWEEP;
                end else begin
                    status_next = sfla_pkg::ST_NOBLK;
                    state_next  = S_DONE;
                end
            end
            S_SWEEP: begin
                mem_we            = 1'b1;
                mem_waddr         = {blk_reg, idx_reg[sfla_pkg::SLOT_W-1:0]};
                mem_wdata.is_free = 1'b1;
                mem_wdata.nxt     = (idx_plus < cap_reg[blk_reg]) ?
                                    idx_plus[sfla_pkg::SLOT_W-1:0] : '0;
                idx_next          = idx_plus;
                if (idx_plus >= cap_reg[blk_reg]) begin
                    if (req_reg == sfla_pkg::REQ_ALLOC) begin
                        state_next = S_ALLOC_RD;
                    end else if (blk_reg == LAST_BLK) begin
                        state_next = S_DONE;
                    end else begin
                        blk_next   = blk_reg + sfla_pkg::BLK_W'(1);
                        state_next = S_CLEAR;
                    end
                end
            end
            S_ALLOC_RD: begin
                state_next = S_ALLOC_WR;
            end
            S_ALLOC_WR: begin
                head_next[blk_reg] = mem_rdata.nxt;
                mem_we             = 1'b1;
                mem_waddr          = {blk_reg, head_reg[blk_reg]};
                mem_wdata.is_free  = 1'b0;
                mem_wdata.nxt      = mem_rdata.nxt;
                cnt_next[blk_reg]  = cnt_dec;
                if (cnt_reg[blk_reg] != '0) begin
                    fs_next = fs_reg - sfla_pkg::FS_W'(1);
                end
                if (cnt_dec == '0) begin
                    lst_next[blk_reg] = sfla_pkg::LST_FULL;
                    order_next        = push_order(order_reg, blk_reg);
                end
                actr_next  = (actr_reg == CNT_SAT) ? actr_reg : actr_reg + sfla_pkg::CNT_W'(1);
                ahdl_next  = {blk_reg, head_reg[blk_reg]};
                state_next = S_DONE;
            end
            S_FREE: begin
                mem_raddr = hdl_reg;
                blk_next  = fblk;
                if (!live_reg[fblk] || ({1'b0, fslot} >= cap_reg[fblk])) begin
                    status_next = sfla_pkg::ST_BADHDL;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_FREE_WR;
                end
            end
            S_FREE_WR: begin
                if (mem_rdata.is_free) begin
                    status_next = sfla_pkg::ST_DBLFREE;
                end else begin
                    mem_we             = 1'b1;
                    mem_waddr          = hdl_reg;
                    mem_wdata.is_free  = 1'b1;
                    mem_wdata.nxt      = head_reg[blk_reg];
                    head_next[blk_reg] = fslot;
                    cnt_next[blk_reg]  = cnt_inc;
                    fs_next            = fs_reg + sfla_pkg::FS_W'(1);
                    fctr_next = (fctr_reg == CNT_SAT) ? fctr_reg : fctr_reg + sfla_pkg::CNT_W'(1);
                    if (cnt_inc >= cap_reg[blk_reg]) begin
                        lst_next[blk_reg] = sfla_pkg::LST_EMPTY;
                        order_next        = push_order(order_reg, blk_reg);
                    end else if (cnt_reg[blk_reg] == '0) begin
                        lst_next[blk_reg] = sfla_pkg::LST_PARTIAL;
                        order_next        = push_order(order_reg, blk_reg);
                    end
                end
                state_next = S_DONE;
            end
            S_TRIM: begin
                if (live_reg[blk_reg] && (lst_reg[blk_reg] == sfla_pkg::LST_EMPTY)) begin
                    live_next[blk_reg] = 1'b0;
                    cnt_next[blk_reg]  = '0;
                    lst_next[blk_reg]  = sfla_pkg::LST_NONE;
                    fs_next            = fs_reg - sfla_pkg::FS_W'(cnt_reg[blk_reg]);
                end
                if (blk_reg == LAST_BLK) begin
                    state_next = S_DONE;
                end else begin
                    blk_next = blk_reg + sfla_pkg::BLK_W'(1);
                end
            end
            S_CLEAR: begin
                if (live_reg[blk_reg]) begin
                    head_next[blk_reg] = '0;
                    cnt_next[blk_reg]  = cap_reg[blk_reg];
                    fs_next            = fs_reg + sfla_pkg::FS_W'(cap_reg[blk_reg]);
                    idx_next           = '0;
                    state_next         = S_SWEEP;
                end else if (blk_reg == LAST_BLK) begin
                    state_next = S_DONE;
                end else begin
                    blk_next = blk_reg + sfla_pkg::BLK_W'(1);
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            slots_reg <= sfla_pkg::CAP_W'(sfla_pkg::MAX_SLOTS);
            limit_reg <= sfla_pkg::LIM_W'(sfla_pkg::MAX_BLOCKS);
            live_reg  <= '0;
            cnt_reg   <= '0;
            cap_reg   <= '0;
            lst_reg   <= {sfla_pkg::MAX_BLOCKS{sfla_pkg::LST_NONE}};
            order_reg <= '0;
            actr_reg  <= '0;
            fctr_reg  <= '0;
            fs_reg    <= '0;
        end else begin
            state_reg <= state_next;
            live_reg  <= live_next;
            cnt_reg   <= cnt_next;
            cap_reg   <= cap_next;
            lst_reg   <= lst_next;
            order_reg <= order_next;
            actr_reg  <= actr_next;
            fctr_reg  <= fctr_next;
            fs_reg    <= fs_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == sfla_pkg::CFG_SLOTS) begin
                    slots_reg <= cfg_data;
                end else begin
                    limit_reg <= cfg_data[sfla_pkg::LIM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        hdl_reg    <= hdl_next;
        status_reg <= status_next;
        ahdl_reg   <= ahdl_next;
        blk_reg    <= blk_next;
        idx_reg    <= idx_next;
        head_reg   <= head_next;
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status       <= status_reg;
            m_alloc_handle <= ahdl_reg;
            m_blocks_live  <= live_cnt;
            m_total_allocs <= actr_reg;
            m_total_frees  <= fctr_reg;
            m_free_slots   <= fs_reg;
        end
    end

    `SFLA_ASSERT_IMPL(a_handle_zero_on_error, aclk, aresetn,
        m_valid && (m_status != sfla_pkg::ST_OK), m_alloc_handle == '0)
    `SFLA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SFLA_ASSERT_IMPL(a_free_slots_bound, aclk, aresetn, m_valid,
        m_free_slots <= (sfla_pkg::FS_W'(m_blocks_live) << sfla_pkg::SLOT_W))

endmodule
